### sv/owrs_pkg.sv
// Package for the 1-Wire ROM search engine: request codes, result codes and CRC helper.
package owrs_pkg;

	localparam int unsigned NUM_BITS    = 64;
	localparam int unsigned FAMILY_BITS = 8;
	localparam int unsigned POS_W       = 6;
	localparam int unsigned DISC_W      = 7;
	localparam int unsigned CRC_W       = 8;
	localparam logic [CRC_W-1:0] CRC_POLY = 8'h8C;
	localparam logic [DISC_W-1:0] DISC_NONE = 7'd64;

	// Request kind carried on the input side.
	typedef enum logic [1:0] {
		ACT_RESTART = 2'd0,
		ACT_FAMILY  = 2'd1,
		ACT_BEGIN   = 2'd2,
		ACT_TRIPLET = 2'd3
	} action_t;

	// Result kind carried on the output side.
	typedef enum logic [2:0] {
		OUT_TRIPLET     = 3'd0,
		OUT_FOUND       = 3'd1,
		OUT_NO_PRESENCE = 3'd2,
		OUT_NO_ANSWER   = 3'd3,
		OUT_BAD_ADDRESS = 3'd4,
		OUT_EXHAUSTED   = 3'd5,
		OUT_ACCEPTED    = 3'd6,
		OUT_IGNORED     = 3'd7
	} outcome_t;

	// One bit step of the reflected CRC-8 (x^8 + x^5 + x^4 + 1).
	function automatic logic [CRC_W-1:0] crc8_step(input logic [CRC_W-1:0] crc,
	                                                input logic din);
		logic mix;
		mix = crc[0] ^ din;
		crc8_step = (crc >> 1) ^ (mix ? CRC_POLY : '0);
	endfunction

endpackage

### sv/onewire_rom_search_engine.sv
// ROM search sequencer: drives a triplet-capable 1-Wire master through the ROM search.
//
// Input channel (s_*): one request per item. tuser selects restart, family
// restart, begin pass (with the reset presence result) or triplet result
// (the two read bits and the direction actually written).
// Output channel (m_*): exactly one result per request: a triplet request
// with the direction and bit index to use, found with the address, or a
// status (no presence, no answer, bad address, exhausted, accepted, ignored),
// plus the current last-device flag.
// Each request passes the input register, then the result register.
// Throughput: one request per cycle unless the receiver stalls; the search state is
// updated by a single pass of logic between the two registers. The address
// CRC is accumulated one bit per triplet, so the check at bit 63 is a compare.
// Reset clears the search: empty address, no lock, discrepancy 64, no pass.
// When the receiver stalls, a held result keeps the request stage full, and
// s_tready drops once both stages hold an item; nothing is dropped.
module onewire_rom_search_engine
	import owrs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] family_byte, [8] presence, [9] id_bit, [10] complement_bit,
	// [11] taken_direction, [15:12] zero
	input  logic [15:0] s_tdata,
	// [1:0] action
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] next_direction, [6:1] next_bit_index, [70:7] found_address,
	// [71] last_device
	output logic [71:0] m_tdata,
	// [2:0] outcome
	output logic [2:0]  m_tuser
);

	// Request stage
	logic              valid_s1;
	action_t           action_s1;
	logic [7:0]        family_s1;
	logic              presence_s1;
	logic              id_bit_s1;
	logic              cmp_bit_s1;
	logic              taken_s1;

	// Search state
	logic [NUM_BITS-1:0] rom_q;
	logic [DISC_W-1:0]   last_disc_q;
	logic                last_dev_q;
	logic                lock_q;
	logic [POS_W-1:0]    pos_q;
	logic [DISC_W-1:0]   last_zero_q;
	logic                active_q;
	logic [CRC_W-1:0]    crc_q;

	// Result register
	logic                out_valid_q;
	outcome_t            outcome_q;
	logic                dir_q;
	logic [POS_W-1:0]    idx_q;
	logic [NUM_BITS-1:0] addr_q;
	logic                last_dev_out_q;

	logic out_free;
	logic fire;

	assign out_free = !out_valid_q || m_tready;
	assign fire     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// Next-state values
	logic [NUM_BITS-1:0] rom_d;
	logic [DISC_W-1:0]   last_disc_d;
	logic                last_dev_d;
	logic                lock_d;
	logic [POS_W-1:0]    pos_d;
	logic [DISC_W-1:0]   last_zero_d;
	logic                active_d;
	logic [CRC_W-1:0]    crc_d;
	outcome_t            outcome_d;
	logic                dir_d;
	logic [POS_W-1:0]    idx_d;
	logic [NUM_BITS-1:0] addr_d;

	// Direction for the bit after the current one (also used for bit 0)
	logic [POS_W-1:0]  pos_next;
	logic [DISC_W-1:0] pos_next_w;
	logic              dir_next;
	logic              dir_zero;
	logic [DISC_W-1:0] zero_new;
	logic [NUM_BITS-1:0] rom_new;

	assign pos_next   = pos_q + POS_W'(1);
	assign pos_next_w = {1'b0, pos_next};
	assign dir_next   = (pos_next_w < last_disc_q || (lock_q && pos_next[POS_W-1:3] == '0))
	                    ? rom_q[pos_next] : (pos_next_w == last_disc_q);
	assign dir_zero   = (last_disc_q != '0 || lock_q) ? rom_q[0] : (last_disc_q == '0);

	// Triplet result folded into the stored address and the zero-branch mark
	assign zero_new = (!id_bit_s1 && !cmp_bit_s1 && !taken_s1) ? {1'b0, pos_q} : last_zero_q;
	always_comb begin
		rom_new        = rom_q;
		rom_new[pos_q] = taken_s1;
	end

	// Request decode and search update
	always_comb begin
		rom_d       = rom_q;
		last_disc_d = last_disc_q;
		last_dev_d  = last_dev_q;
		lock_d      = lock_q;
		pos_d       = pos_q;
		last_zero_d = last_zero_q;
		active_d    = active_q;
		crc_d       = crc_q;
		outcome_d   = OUT_ACCEPTED;
		dir_d       = 1'b0;
		idx_d       = '0;
		addr_d      = '0;
		unique case (action_s1)
			ACT_RESTART, ACT_FAMILY: begin
				rom_d       = (action_s1 == ACT_FAMILY)
				              ? {{(NUM_BITS-FAMILY_BITS){1'b0}}, family_s1} : '0;
				lock_d      = (action_s1 == ACT_FAMILY);
				last_disc_d = DISC_NONE;
				last_dev_d  = 1'b0;
				pos_d       = '0;
				last_zero_d = DISC_NONE;
				active_d    = 1'b0;
			end
			ACT_BEGIN: begin
				if (last_dev_q) begin
					active_d  = 1'b0;
					outcome_d = OUT_EXHAUSTED;
				end else if (!presence_s1) begin
					active_d  = 1'b0;
					outcome_d = OUT_NO_PRESENCE;
				end else begin
					active_d    = 1'b1;
					pos_d       = '0;
					last_zero_d = DISC_NONE;
					crc_d       = '0;
					outcome_d   = OUT_TRIPLET;
					dir_d       = dir_zero;
				end
			end
			ACT_TRIPLET: begin
				if (!active_q) begin
					outcome_d = OUT_IGNORED;
				end else if (id_bit_s1 && cmp_bit_s1) begin
					active_d  = 1'b0;
					outcome_d = OUT_NO_ANSWER;
				end else begin
					last_zero_d = zero_new;
					rom_d       = rom_new;
					pos_d       = pos_next;
					// Only the first seven bytes feed the CRC
					if (pos_q[POS_W-1:3] != 3'd7) begin
						crc_d = crc8_step(crc_q, taken_s1);
					end
					if (pos_q != '1) begin
						outcome_d = OUT_TRIPLET;
						dir_d     = dir_next;
						idx_d     = pos_next;
					end else begin
						active_d = 1'b0;
						if (crc_q == rom_new[NUM_BITS-1 -: CRC_W]) begin
							last_disc_d = zero_new;
							if (zero_new == DISC_NONE ||
							    (lock_q && zero_new < DISC_W'(FAMILY_BITS))) begin
								last_dev_d = 1'b1;
							end
							outcome_d = OUT_FOUND;
							addr_d    = rom_new;
						end else begin
							outcome_d = OUT_BAD_ADDRESS;
						end
					end
				end
			end
			default: begin
				outcome_d = OUT_IGNORED;
			end
		endcase
	end

	// Request stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Request stage payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1   <= action_t'(s_tuser);
			family_s1   <= s_tdata[7:0];
			presence_s1 <= s_tdata[8];
			id_bit_s1   <= s_tdata[9];
			cmp_bit_s1  <= s_tdata[10];
			taken_s1    <= s_tdata[11];
		end
	end

	// Search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_q       <= '0;
			last_disc_q <= DISC_NONE;
			last_dev_q  <= 1'b0;
			lock_q      <= 1'b0;
			pos_q       <= '0;
			last_zero_q <= DISC_NONE;
			active_q    <= 1'b0;
			crc_q       <= '0;
		end else if (fire) begin
			rom_q       <= rom_d;
			last_disc_q <= last_disc_d;
			last_dev_q  <= last_dev_d;
			lock_q      <= lock_d;
			pos_q       <= pos_d;
			last_zero_q <= last_zero_d;
			active_q    <= active_d;
			crc_q       <= crc_d;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (fire) begin
			outcome_q      <= outcome_d;
			dir_q          <= dir_d;
			idx_q          <= idx_d;
			addr_q         <= addr_d;
			last_dev_out_q <= last_dev_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = outcome_q;
	assign m_tdata  = {last_dev_out_q, addr_q, idx_q, dir_q};

`ifndef ASSERT_OFF
	// A pass never runs once the last device has been found
	a_no_pass_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> !last_dev_q)
		else $error("search pass active with last-device flag set");

	// Only a found result carries an address
	a_addr_only_found: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && outcome_q != OUT_FOUND) |-> addr_q == '0)
		else $error("address reported without found outcome");

	// A held result keeps the request stage from advancing
	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> $stable(rom_q) && $stable(pos_q) && $stable(active_q))
		else $error("search state moved while result stalled");
`endif

endmodule

### tb/onewire_rom_search_engine_tb.sv
`timescale 1ns / 1ps
// Testbench for onewire_rom_search_engine: emulated device populations with self-checking prediction.
module onewire_rom_search_engine_tb
	import owrs_pkg::*;
();

	localparam int unsigned TARGET_REQUESTS = 500;
	localparam int unsigned WATCHDOG_LIMIT  = 1000;
	localparam int unsigned MAX_DEVICES     = 8;

	// One expected or observed result
	typedef struct packed {
		outcome_t    outcome;
		logic        dir;
		logic [5:0]  index;
		logic [63:0] addr;
		logic        last;
	} search_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// [7:0] family_byte, [8] presence, [9] id_bit, [10] complement_bit,
	// [11] taken_direction, [15:12] zero
	logic [15:0] s_tdata;
	// [1:0] action
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	// [0] next_direction, [6:1] next_bit_index, [70:7] found_address,
	// [71] last_device
	logic [71:0] m_tdata;
	// [2:0] outcome
	logic [2:0]  m_tuser;

	onewire_rom_search_engine DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Search state mirror
	logic [63:0] rom_image;
	logic [6:0]  disc_mark;
	logic        done_flag;
	logic [3:0]  lock_count;
	logic [6:0]  bit_ptr;
	logic [6:0]  zero_mark;
	logic        in_pass;

	search_result_t pending_results[$];
	int unsigned    requests_sent;
	int unsigned    mismatches;
	int unsigned    quiet_cycles;
	bit             tx_idle;
	bit             rx_idle;

	// Emulated devices on the bus and which of them still follow the current pass
	logic [63:0] devices[$];
	bit          alive[MAX_DEVICES];

	// Reflected CRC-8 over the 56 body bits, LSB first
	function automatic logic [7:0] dallas_crc(input logic [55:0] body);
		logic [7:0] c;
		logic       mix;
		c = 8'h00;
		for (int i = 0; i < 56; i++) begin
			mix = c[0] ^ body[i];
			c = (c >> 1) ^ (mix ? CRC_POLY : 8'h00);
		end
		return c;
	endfunction

	function automatic void clear_search(input logic [63:0] start, input logic [3:0] lock);
		rom_image  = start;
		disc_mark  = DISC_NONE;
		done_flag  = 1'b0;
		lock_count = lock;
		bit_ptr    = 7'd0;
		zero_mark  = DISC_NONE;
		in_pass    = 1'b0;
	endfunction

	// Direction rule: stored bit below discrepancy or inside lock, 1 at it, 0 above
	function automatic logic steer_bit(input logic [6:0] pos);
		if (pos < disc_mark || pos < {3'b000, lock_count})
			return rom_image[pos[5:0]];
		return pos == disc_mark;
	endfunction

	// Predicts the result of one accepted request and advances the mirror
	function automatic search_result_t search_step(input action_t act, input logic [7:0] fam,
		input logic pres, input logic idb, input logic cmpb, input logic taken);
		search_result_t r;
		logic [5:0]     pos;
		r.outcome = OUT_ACCEPTED;
		r.dir     = 1'b0;
		r.index   = 6'd0;
		r.addr    = 64'd0;
		case (act)
			ACT_RESTART: clear_search(64'd0, 4'd0);
			ACT_FAMILY: clear_search({56'd0, fam}, 4'(FAMILY_BITS));
			ACT_BEGIN: begin
				if (done_flag) begin
					in_pass = 1'b0;
					r.outcome = OUT_EXHAUSTED;
				end else if (!pres) begin
					in_pass = 1'b0;
					r.outcome = OUT_NO_PRESENCE;
				end else begin
					in_pass   = 1'b1;
					bit_ptr   = 7'd0;
					zero_mark = DISC_NONE;
					r.outcome = OUT_TRIPLET;
					r.dir     = steer_bit(7'd0);
				end
			end
			default: begin
				if (!in_pass) begin
					r.outcome = OUT_IGNORED;
				end else if (idb && cmpb) begin
					in_pass = 1'b0;
					r.outcome = OUT_NO_ANSWER;
				end else begin
					pos = bit_ptr[5:0];
					// zero branch: both devices kinds present, 0 written
					if (!idb && !cmpb && !taken)
						zero_mark = {1'b0, pos};
					rom_image[pos] = taken;
					bit_ptr = {1'b0, pos} + 7'd1;
					if (bit_ptr < 7'(NUM_BITS)) begin
						r.outcome = OUT_TRIPLET;
						r.dir     = steer_bit(bit_ptr);
						r.index   = bit_ptr[5:0];
					end else begin
						in_pass = 1'b0;
						if (dallas_crc(rom_image[55:0]) == rom_image[63:56]) begin
							disc_mark = zero_mark;
							if (zero_mark == DISC_NONE || zero_mark < {3'b000, lock_count})
								done_flag = 1'b1;
							r.outcome = OUT_FOUND;
							r.addr    = rom_image;
						end else begin
							r.outcome = OUT_BAD_ADDRESS;
						end
					end
				end
			end
		endcase
		r.last = done_flag;
		return r;
	endfunction

	// Sends one request after a random gap and records its expected result
	task automatic send_request(input action_t act, input logic [7:0] fam, input logic pres,
		input logic idb, input logic cmpb, input logic taken, output search_result_t r);
		int unsigned gap;
		if ($urandom_range(0, 39) == 0)
			tx_idle = !tx_idle;
		gap = tx_idle ? $urandom_range(0, 14) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {4'b0000, taken, cmpb, idb, pres, fam};
		do @(posedge clk); while (s_tready !== 1'b1);
		r = search_step(act, fam, pres, idb, cmpb, taken);
		pending_results.push_back(r);
		requests_sent++;
	endtask

	// Builds a population; siblings share most bits so branches appear
	task automatic new_population(input int unsigned count, input bit with_bad);
		logic [55:0] base;
		logic [55:0] body;
		int unsigned pick;
		int unsigned flip;
		devices.delete();
		base = 56'({$urandom, $urandom});
		for (int unsigned k = 0; k < count; k++) begin
			body = base;
			if (k != 0) begin
				if ($urandom_range(0, 5) == 0) begin
					body = 56'({$urandom, $urandom});
				end else begin
					repeat ($urandom_range(1, 3)) begin
						pick = $urandom_range(0, 55);
						body[pick] = ~body[pick];
					end
				end
			end
			devices.push_back({dallas_crc(body), body});
		end
		// one CRC bit of one device flipped
		if (with_bad && count != 0) begin
			pick = $urandom_range(0, count - 1);
			flip = 56 + $urandom_range(0, 7);
			devices[pick][flip] = ~devices[pick][flip];
		end
	endtask

	// One pass over the emulated bus, answering each requested triplet
	task automatic run_search_pass(input bit noisy, output search_result_t r);
		logic       pres;
		logic       any0;
		logic       any1;
		logic       idb;
		logic       cmpb;
		logic       taken;
		logic [5:0] idx;
		pres = devices.size() != 0;
		if (noisy && $urandom_range(0, 7) == 0)
			pres = ~pres;
		send_request(ACT_BEGIN, 8'($urandom), pres, 1'($urandom), 1'($urandom),
			1'($urandom), r);
		foreach (alive[k])
			alive[k] = k < devices.size();
		while (r.outcome == OUT_TRIPLET) begin
			idx  = r.index;
			any0 = 1'b0;
			any1 = 1'b0;
			foreach (devices[k]) begin
				if (alive[k]) begin
					if (devices[k][idx])
						any1 = 1'b1;
					else
						any0 = 1'b1;
				end
			end
			// wired-AND read of the bit and its complement
			idb   = !any0;
			cmpb  = !any1;
			taken = (idb != cmpb) ? idb : r.dir;
			if (noisy && $urandom_range(0, 47) == 0) begin
				case ($urandom_range(0, 2))
					0: idb = ~idb;
					1: cmpb = ~cmpb;
					default: taken = ~taken;
				endcase
			end
			foreach (devices[k])
				if (devices[k][idx] != taken)
					alive[k] = 1'b0;
			send_request(ACT_TRIPLET, 8'($urandom), 1'($urandom), idb, cmpb, taken, r);
		end
	endtask

	// Requests outside a pass, and a begin without presence
	task automatic test_idle_requests();
		search_result_t r;
		send_request(ACT_RESTART, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, r);
		send_request(ACT_TRIPLET, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, r);
		send_request(ACT_TRIPLET, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, r);
		send_request(ACT_BEGIN, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b1, r);
		send_request(ACT_TRIPLET, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, r);
	endtask

	// Family lock at both extremes, restarted pass, no answer, lost presence
	task automatic test_family_lock();
		search_result_t r;
		send_request(ACT_FAMILY, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, r);
		send_request(ACT_BEGIN, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, r);
		send_request(ACT_TRIPLET, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, r);
		send_request(ACT_TRIPLET, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, r);
		send_request(ACT_TRIPLET, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1, r);
		send_request(ACT_TRIPLET, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, r);
		send_request(ACT_BEGIN, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, r);
		send_request(ACT_TRIPLET, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, r);
		send_request(ACT_TRIPLET, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, r);
		send_request(ACT_TRIPLET, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, r);
		send_request(ACT_FAMILY, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1, r);
		send_request(ACT_BEGIN, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, r);
		send_request(ACT_TRIPLET, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, r);
		send_request(ACT_TRIPLET, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1, r);
		send_request(ACT_BEGIN, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, r);
		send_request(ACT_TRIPLET, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, r);
		send_request(ACT_RESTART, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, r);
	endtask

	// Enumeration of a fresh population until the search is exhausted, presence is lost or the pass limit is reached
	task automatic test_device_search(input bit force_bad);
		search_result_t r;
		int unsigned    count;
		bit             noisy;
		logic [7:0]     fam;
		count = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
		new_population(count, force_bad || $urandom_range(0, 3) == 0);
		noisy = $urandom_range(0, 4) == 0;
		if ($urandom_range(0, 2) == 0) begin
			fam = (count != 0 && $urandom_range(0, 3) != 0) ? devices[0][7:0] : 8'($urandom);
			send_request(ACT_FAMILY, fam, 1'($urandom), 1'($urandom), 1'($urandom),
				1'($urandom), r);
		end else begin
			send_request(ACT_RESTART, 8'($urandom), 1'($urandom), 1'($urandom),
				1'($urandom), 1'($urandom), r);
		end
		for (int unsigned p = 0; p < count + 3; p++) begin
			run_search_pass(noisy, r);
			if (r.outcome == OUT_EXHAUSTED || r.outcome == OUT_NO_PRESENCE)
				break;
		end
	endtask

	// Pass cut short by random reads, then optionally a restart or a new begin
	task automatic test_broken_pass();
		search_result_t r;
		logic           idb;
		logic           cmpb;
		send_request(ACT_BEGIN, 8'($urandom), 1'b1, 1'($urandom), 1'($urandom),
			1'($urandom), r);
		repeat ($urandom_range(0, 70)) begin
			if ($urandom_range(0, 15) == 0) begin
				idb  = 1'b1;
				cmpb = 1'b1;
			end else begin
				idb  = 1'($urandom);
				cmpb = idb ? 1'b0 : 1'($urandom);
			end
			send_request(ACT_TRIPLET, 8'($urandom), 1'($urandom), idb, cmpb,
				1'($urandom), r);
		end
		case ($urandom_range(0, 2))
			0: send_request(ACT_RESTART, 8'($urandom), 1'($urandom), 1'($urandom),
				1'($urandom), 1'($urandom), r);
			1: send_request(ACT_BEGIN, 8'($urandom), 1'($urandom), 1'($urandom),
				1'($urandom), 1'($urandom), r);
			default: ;
		endcase
	endtask

	// Fully random requests of any kind
	task automatic test_noise();
		search_result_t r;
		repeat ($urandom_range(1, 8))
			send_request(action_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
				1'($urandom), 1'($urandom), 1'($urandom), r);
	endtask

	// Result side: random stalls, compare against the oldest expectation
	initial begin : result_monitor
		search_result_t want;
		int unsigned    stall;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 39) == 0)
				rx_idle = !rx_idle;
			stall = rx_idle ? $urandom_range(0, 14) : 0;
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			if (pending_results.size() == 0) begin
				$error("unexpected result: outcome %0d", m_tuser);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.outcome) begin
					$error("outcome: expected %0d, got %0d", want.outcome, m_tuser);
					mismatches++;
				end
				if (m_tdata[0] !== want.dir) begin
					$error("next_direction: expected %0d, got %0d", want.dir, m_tdata[0]);
					mismatches++;
				end
				if (m_tdata[6:1] !== want.index) begin
					$error("next_bit_index: expected %0d, got %0d", want.index, m_tdata[6:1]);
					mismatches++;
				end
				if (m_tdata[70:7] !== want.addr) begin
					$error("found_address: expected %h, got %h", want.addr, m_tdata[70:7]);
					mismatches++;
				end
				if (m_tdata[71] !== want.last) begin
					$error("last_device: expected %0d, got %0d", want.last, m_tdata[71]);
					mismatches++;
				end
			end
		end
	end

	// Watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("onewire_rom_search_engine test failed");
			$finish;
		end
	end

	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= 16'h0000;
		s_tuser  <= ACT_RESTART;
		m_tready <= 1'b0;
		requests_sent = 0;
		mismatches    = 0;
		quiet_cycles  = 0;
		tx_idle       = 1'b1;
		rx_idle       = 1'b1;
		clear_search(64'd0, 4'd0);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_requests();
		test_family_lock();
		test_device_search(1'b1);
		while (requests_sent < TARGET_REQUESTS) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5, 6: test_device_search(1'b0);
				7, 8: test_broken_pass();
				default: test_noise();
			endcase
		end
		s_tvalid <= 1'b0;

		// drain, then allow for the pipeline depth
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("onewire_rom_search_engine test passed");
		else
			$display("onewire_rom_search_engine test failed");
		$finish;
	end

endmodule
